FILE: hw/rtl/phtn_pkg.sv
// ----------------------------------------------------------------------------
// Point hashed table noise package
// Shared constants and the queue item type of the noise core.
// ----------------------------------------------------------------------------
package phtn_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int CFG_W = 9;

    localparam logic [31:0] EXP_MASK = 32'h0780_0000;
    localparam logic [31:0] MAN_MASK = 32'h007f_ffff;
    localparam logic [31:0] HASH_MUL = 32'd1665636;
    localparam logic [31:0] HASH_ADD = 32'd1013904223;

    localparam logic [16:0]        T_ONE = 17'h1_0000;
    localparam logic signed [31:0] T_MAX = 32'sh0001_0000;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    typedef struct packed {
        logic               is_query;
        logic               wr_en;
        logic signed [31:0] value;
        logic [15:0]        frac;
    } t_item;

endpackage

FILE: hw/rtl/phtn_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Carries load and query transactions into the noise core.
// ----------------------------------------------------------------------------
interface phtn_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [31:0]        point_x;
    logic [31:0]        point_y;
    logic [31:0]        point_z;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic signed [31:0] table_pos;

    modport source (
        output valid, cmd, entry_index, entry_value, point_x, point_y, point_z,
        output range_low, range_high, table_pos,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_value, point_x, point_y, point_z,
        input  range_low, range_high, table_pos,
        output ready
    );
endinterface

FILE: hw/rtl/phtn_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Carries noise result transactions out of the noise core.
// ----------------------------------------------------------------------------
interface phtn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] noise_value;
    logic               saturated;

    modport source (output valid, noise_value, saturated, input ready);
    modport sink (input valid, noise_value, saturated, output ready);
endinterface

FILE: hw/rtl/phtn_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries writes of the table length register.
// ----------------------------------------------------------------------------
interface phtn_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/point_hashed_table_noise_core.sv
// ----------------------------------------------------------------------------
// Point hashed table noise core
// Top level: table length register, front end, item queue and back end.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of transaction. A load (cmd 0) writes
// one entry of the scale table and gives no result; a query (cmd 1) gives
// exactly one result on the output channel, in the order of acceptance.
// The configuration channel writes the table length and is always ready; the
// user must write it only while no transaction is in flight, and the block
// itself does not enforce this.
// Both ends take one transaction per cycle unless the receiver stalls; a
// query passes the two-stage front end, the queue and the five-stage back
// end with its multipliers. On a stall the output register holds its result,
// the back end fills, then the four-entry queue and the front end; only then
// does the input ready fall, and nothing is lost or repeated.
// Reset is synchronous and active low. It empties the pipelines and the
// queue and sets the table length to one. The scale table is not cleared and
// must be loaded before it is read.
// ----------------------------------------------------------------------------
module point_hashed_table_noise_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phtn_in_if.sink     i_in,
    phtn_out_if.source  o_out,
    phtn_cfg_if.sink    i_cfg
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CW     = (LEN_W > phtn_pkg::CFG_W) ? LEN_W : phtn_pkg::CFG_W;
    localparam int Q_W    = $bits(phtn_pkg::t_item) + 2 * IDX_W;

    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [CW-1:0]     cfg_w;

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    phtn_pkg::t_item   f_item;
    logic [IDX_W-1:0]  f_addr_a;
    logic [IDX_W-1:0]  f_addr_b;
    logic [Q_W-1:0]    q_wdata;
    logic [Q_W-1:0]    q_rdata;
    phtn_pkg::t_item   b_item;
    logic [IDX_W-1:0]  b_addr_a;
    logic [IDX_W-1:0]  b_addr_b;

    assign i_cfg.ready = 1'b1;
    assign cfg_w       = CW'(i_cfg.data);

    // A length of zero acts as one, and one beyond the depth as the depth.
    always_comb begin
        priority if (cfg_w == '0) begin
            n_len = LEN_W'(1);
        end else if (cfg_w > CW'(TABLE_DEPTH)) begin
            n_len = LEN_W'(TABLE_DEPTH);
        end else begin
            n_len = LEN_W'(cfg_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            r_len <= n_len;
        end
    end

    phtn_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_len    (r_len),
        .i_full   (full),
        .o_push   (push),
        .o_item   (f_item),
        .o_addr_a (f_addr_a),
        .o_addr_b (f_addr_b)
    );

    assign q_wdata = {f_item, f_addr_a, f_addr_b};

    phtn_fifo #(.WIDTH(Q_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {b_item, b_addr_a, b_addr_b} = q_rdata;

    phtn_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_item   (b_item),
        .i_addr_a (b_addr_a),
        .i_addr_b (b_addr_b),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

FILE: hw/rtl/phtn_front.sv
// ----------------------------------------------------------------------------
// Noise core front end
// Accepts transactions, hashes the point, maps the fraction into range and
// works out the two table addresses, then pushes items into the queue.
// ----------------------------------------------------------------------------
module phtn_front #(
    parameter int  TABLE_DEPTH = 256,
    localparam int IDX_W       = $clog2(TABLE_DEPTH),
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1),
    localparam int P_W         = 17 + LEN_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    phtn_in_if.sink            i_in,
    input  logic [LEN_W-1:0]   i_len,
    input  logic               i_full,
    output logic               o_push,
    output phtn_pkg::t_item    o_item,
    output logic [IDX_W-1:0]   o_addr_a,
    output logic [IDX_W-1:0]   o_addr_b
);

    logic en1;
    logic en2;

    logic [10:0]        part_x;
    logic [10:0]        part_y;
    logic [10:0]        part_z;
    logic [31:0]        key;
    logic [22:0]        n_hprod;
    logic [16:0]        t_clamp;
    logic [P_W-1:0]     n_p;
    logic signed [32:0] n_diff;
    logic               n_wr_en;

    logic                r1_valid;
    logic                r1_cmd;
    logic                r1_wr_en;
    logic [IDX_W-1:0]    r1_wr_addr;
    logic signed [31:0]  r1_wr_data;
    logic [22:0]         r1_hprod;
    logic signed [31:0]  r1_lo;
    logic signed [32:0]  r1_diff;
    logic [P_W-1:0]      r1_p;

    logic [22:0]         r23;
    logic signed [56:0]  diff_w;
    logic signed [56:0]  r23_w;
    logic signed [56:0]  n_vprod;
    logic [LEN_W:0]      idx;
    logic [LEN_W:0]      idx1;
    logic [LEN_W:0]      len_x;
    logic [LEN_W:0]      last;
    logic [IDX_W-1:0]    n_addr_a;
    logic [IDX_W-1:0]    n_addr_b;

    logic                r2_valid;
    logic                r2_cmd;
    logic                r2_wr_en;
    logic signed [31:0]  r2_lo;
    logic signed [31:0]  r2_wr_data;
    logic signed [56:0]  r2_vprod;
    logic [IDX_W-1:0]    r2_addr_a;
    logic [IDX_W-1:0]    r2_addr_b;
    logic [15:0]         r2_frac;

    logic signed [31:0]  v;

    assign en2       = !r2_valid || !i_full;
    assign en1       = !r1_valid || en2;
    assign i_in.ready = en1;
    assign o_push    = r2_valid && !i_full;

    assign part_x = 11'((i_in.point_x & phtn_pkg::EXP_MASK) >> 16)
                  | 11'((i_in.point_x & phtn_pkg::MAN_MASK) >> 17);
    assign part_y = 11'((i_in.point_y & phtn_pkg::EXP_MASK) >> 16)
                  | 11'((i_in.point_y & phtn_pkg::MAN_MASK) >> 17);
    assign part_z = 11'((i_in.point_z & phtn_pkg::EXP_MASK) >> 16)
                  | 11'((i_in.point_z & phtn_pkg::MAN_MASK) >> 17);
    assign key    = (32'(part_x) << 20) | (32'(part_y) << 10) | 32'(part_z);

    // Only the low 23 bits of the hash are kept, so a 23-bit product suffices.
    assign n_hprod = key[22:0] * phtn_pkg::HASH_MUL[22:0];
    assign n_diff  = 33'(i_in.range_high) - 33'(i_in.range_low);
    assign n_p     = P_W'(t_clamp) * P_W'(i_len);
    assign n_wr_en = int'(i_in.entry_index) < TABLE_DEPTH;

    always_comb begin
        priority if (i_in.table_pos[31]) begin
            t_clamp = '0;
        end else if (i_in.table_pos > phtn_pkg::T_MAX) begin
            t_clamp = phtn_pkg::T_ONE;
        end else begin
            t_clamp = i_in.table_pos[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cmd     <= i_in.cmd;
            r1_wr_en   <= n_wr_en;
            r1_wr_addr <= IDX_W'(i_in.entry_index);
            r1_wr_data <= i_in.entry_value;
            r1_hprod   <= n_hprod;
            r1_lo      <= i_in.range_low;
            r1_diff    <= n_diff;
            r1_p       <= n_p;
        end
    end

    assign r23     = r1_hprod + phtn_pkg::HASH_ADD[22:0];
    assign diff_w  = 57'(r1_diff);
    assign r23_w   = {34'd0, r23};
    assign n_vprod = diff_w * r23_w;

    // Reads at or beyond the table length repeat the last entry.
    assign idx   = r1_p[P_W-1:16];
    assign idx1  = idx + 1'b1;
    assign len_x = (LEN_W + 1)'(i_len);
    assign last  = len_x - 1'b1;

    always_comb begin
        n_addr_a = (idx >= len_x)  ? IDX_W'(last) : IDX_W'(idx);
        n_addr_b = (idx1 >= len_x) ? IDX_W'(last) : IDX_W'(idx1);
        if (r1_cmd == phtn_pkg::CMD_LOAD) begin
            n_addr_a = r1_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_cmd     <= r1_cmd;
            r2_wr_en   <= r1_wr_en;
            r2_lo      <= r1_lo;
            r2_wr_data <= r1_wr_data;
            r2_vprod   <= n_vprod;
            r2_addr_a  <= n_addr_a;
            r2_addr_b  <= n_addr_b;
            r2_frac    <= r1_p[15:0];
        end
    end

    assign v = r2_lo + 32'(r2_vprod >>> 23);

    assign o_item.is_query = (r2_cmd == phtn_pkg::CMD_QUERY);
    assign o_item.wr_en    = (r2_cmd == phtn_pkg::CMD_LOAD) && r2_wr_en;
    assign o_item.value    = (r2_cmd == phtn_pkg::CMD_QUERY) ? v : r2_wr_data;
    assign o_item.frac     = r2_frac;
    assign o_addr_a        = r2_addr_a;
    assign o_addr_b        = r2_addr_b;

endmodule

FILE: hw/rtl/phtn_fifo.sv
// ----------------------------------------------------------------------------
// Noise core item queue
// A short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module phtn_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0]                r_mem [phtn_pkg::QUEUE_DEPTH];
    logic [phtn_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [phtn_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [phtn_pkg::Q_CNT_W-1:0]    r_count;
    logic [phtn_pkg::Q_CNT_W-1:0]    n_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == phtn_pkg::Q_CNT_W'(phtn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Queue pushed while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Queue popped while empty.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= phtn_pkg::Q_CNT_W'(phtn_pkg::QUEUE_DEPTH))
        else $error("Queue count out of range.");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Queue count did not follow a lone push.");

endmodule

FILE: hw/rtl/phtn_back.sv
// ----------------------------------------------------------------------------
// Noise core back end
// Holds the scale table, interpolates the scale and forms the saturated
// product, ending in the output register.
// ----------------------------------------------------------------------------
module phtn_back #(
    parameter int  TABLE_DEPTH = 256,
    localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  phtn_pkg::t_item    i_item,
    input  logic [IDX_W-1:0]   i_addr_a,
    input  logic [IDX_W-1:0]   i_addr_b,
    output logic               o_pop,
    phtn_out_if.source         o_out
);

    logic signed [31:0] r_table [TABLE_DEPTH];

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    logic               r1_valid;
    logic signed [31:0] r1_a;
    logic signed [31:0] r1_b;
    logic signed [31:0] r1_v;
    logic [15:0]        r1_frac;

    logic signed [49:0] diff_w;
    logic signed [49:0] frac_w;
    logic signed [49:0] n_sprod;
    logic               r2_valid;
    logic signed [49:0] r2_sprod;
    logic signed [31:0] r2_a;
    logic signed [31:0] r2_v;

    logic signed [31:0] n_s;
    logic               r3_valid;
    logic signed [31:0] r3_s;
    logic signed [31:0] r3_v;

    logic signed [63:0] n_prod;
    logic               r4_valid;
    logic signed [63:0] r4_prod;

    logic               in_range;
    logic signed [31:0] n_value;
    logic               r5_valid;
    logic signed [31:0] r5_value;
    logic               r5_sat;

    assign en5   = !r5_valid || o_out.ready;
    assign en4   = !r4_valid || en5;
    assign en3   = !r3_valid || en4;
    assign en2   = !r2_valid || en3;
    assign en1   = !r1_valid || en2;
    assign o_pop = !i_empty && en1;

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.is_query && i_item.wr_en) begin
            r_table[i_addr_a] <= i_item.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_a    <= r_table[i_addr_a];
            r1_b    <= r_table[i_addr_b];
            r1_v    <= i_item.value;
            r1_frac <= i_item.frac;
        end
    end

    assign diff_w  = 50'(r1_b) - 50'(r1_a);
    assign frac_w  = {34'd0, r1_frac};
    assign n_sprod = diff_w * frac_w;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sprod <= n_sprod;
            r2_a     <= r1_a;
            r2_v     <= r1_v;
        end
    end

    assign n_s = r2_a + 32'(r2_sprod >>> 16);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_s <= n_s;
            r3_v <= r2_v;
        end
    end

    assign n_prod = 64'(r3_v) * 64'(r3_s);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_prod <= n_prod;
        end
    end

    assign in_range = (r4_prod[63:47] == '0) || (r4_prod[63:47] == '1);

    always_comb begin
        priority if (in_range) begin
            n_value = r4_prod[47:16];
        end else if (r4_prod[63]) begin
            n_value = 32'sh8000_0000;
        end else begin
            n_value = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_value <= n_value;
            r5_sat   <= !in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= o_pop && i_item.is_query;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
            if (en5) begin
                r5_valid <= r4_valid;
            end
        end
    end

    assign o_out.valid       = r5_valid;
    assign o_out.noise_value = r5_value;
    assign o_out.saturated   = r5_sat;

endmodule
